// File: hw/rtl/ttk_pkg.sv
package ttk_pkg;

   typedef enum logic [1:0] {
      KIND_TICK       = 2'd0,
      KIND_LOAD_DELAY = 2'd1,
      KIND_LOAD_SEC   = 2'd2,
      KIND_LOAD_MIN   = 2'd3
   } kind_type;

   localparam logic [9:0] MS_MAX        = 10'd999;
   localparam logic [5:0] SEC_MAX       = 6'd59;
   localparam logic [5:0] MIN_MAX       = 6'd59;
   localparam logic [4:0] HOUR_MAX      = 5'd23;
   localparam logic [9:0] LED_ONE_LIMIT = 10'd200;
   localparam logic [9:0] LED_TWO_LIMIT = 10'd400;
   localparam logic [9:0] SAMPLE_PERIOD = 10'd4;
   // The period is a power of two, so the multiple test is a mask.
   localparam logic [9:0] SAMPLE_MASK   = SAMPLE_PERIOD - 10'd1;

endpackage

// File: hw/rtl/tick_timekeeper_with_countdowns.sv
// The result of an item is shown in the cycle after its transfer.
// Throughput: one item per cycle; the state registers are the result register,
// so a new item is taken whenever the shown result is taken or none is shown.
// Reset (synchronous, active high) clears the clock, the tick count, the three
// countdowns, both LEDs, the sample trigger and sample enable; no result is
// shown after reset.
module tick_timekeeper_with_countdowns (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_milliseconds,
   output logic [5:0]  rsp_seconds,
   output logic [5:0]  rsp_minutes,
   output logic [4:0]  rsp_hours,
   output logic [15:0] rsp_delay_remaining,
   output logic [15:0] rsp_second_countdown,
   output logic [15:0] rsp_minute_countdown,
   output logic        rsp_heartbeat_led_one,
   output logic        rsp_heartbeat_led_two,
   output logic        rsp_sample_trigger,
   output logic [15:0] rsp_tick_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_sample_enable
);

   logic        sample_enable_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  ms_ff, ms_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] sec_down_ff, sec_down_in;
   logic [15:0] min_down_ff, min_down_in;
   logic [1:0]  led_ff, led_in;
   logic        trig_ff, trig_in;
   logic        accept;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ms_in        = ms_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      tick_in      = tick_ff;
      delay_in     = delay_ff;
      sec_down_in  = sec_down_ff;
      min_down_in  = min_down_ff;
      led_in       = led_ff;
      trig_in      = trig_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         trig_in      = 1'b0;
         case (req_kind)
            ttk_pkg::KIND_TICK: begin
               tick_in = tick_ff + 16'd1;
               if (delay_ff != 16'd0) begin
                  delay_in = delay_ff - 16'd1;
               end
               trig_in = sample_enable_ff && ((ms_ff & ttk_pkg::SAMPLE_MASK) == 10'd0);

               // LEDs follow the millisecond value from before this tick.
               if (ms_ff < ttk_pkg::LED_ONE_LIMIT) begin
                  led_in = 2'b01;
               end else if (ms_ff > ttk_pkg::LED_ONE_LIMIT &&
                            ms_ff < ttk_pkg::LED_TWO_LIMIT) begin
                  led_in = 2'b10;
               end else begin
                  led_in = 2'b00;
               end

               if (ms_ff >= ttk_pkg::MS_MAX) begin
                  ms_in = 10'd0;
                  if (sec_down_ff != 16'd0) begin
                     sec_down_in = sec_down_ff - 16'd1;
                  end
                  if (sec_ff >= ttk_pkg::SEC_MAX) begin
                     sec_in = 6'd0;
                     if (min_down_ff != 16'd0) begin
                        min_down_in = min_down_ff - 16'd1;
                     end
                     if (min_ff >= ttk_pkg::MIN_MAX) begin
                        min_in = 6'd0;
                        if (hour_ff >= ttk_pkg::HOUR_MAX) begin
                           hour_in = 5'd0;
                        end else begin
                           hour_in = hour_ff + 5'd1;
                        end
                     end else begin
                        min_in = min_ff + 6'd1;
                     end
                  end else begin
                     sec_in = sec_ff + 6'd1;
                  end
               end else begin
                  ms_in = ms_ff + 10'd1;
               end
            end
            ttk_pkg::KIND_LOAD_DELAY: begin
               delay_in = req_load_value;
            end
            ttk_pkg::KIND_LOAD_SEC: begin
               sec_down_in = req_load_value;
            end
            ttk_pkg::KIND_LOAD_MIN: begin
               min_down_in = req_load_value;
            end
            default: begin
               min_down_in = req_load_value;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_enable_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         ms_ff            <= '0;
         sec_ff           <= '0;
         min_ff           <= '0;
         hour_ff          <= '0;
         tick_ff          <= '0;
         delay_ff         <= '0;
         sec_down_ff      <= '0;
         min_down_ff      <= '0;
         led_ff           <= '0;
         trig_ff          <= 1'b0;
      end else begin
         if (csr_valid) begin
            sample_enable_ff <= csr_sample_enable;
         end
         rsp_valid_ff <= rsp_valid_in;
         ms_ff        <= ms_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         tick_ff      <= tick_in;
         delay_ff     <= delay_in;
         sec_down_ff  <= sec_down_in;
         min_down_ff  <= min_down_in;
         led_ff       <= led_in;
         trig_ff      <= trig_in;
      end
   end

   // The state registers hold the state after the last item, which is the result.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_milliseconds      = ms_ff;
   assign rsp_seconds           = sec_ff;
   assign rsp_minutes           = min_ff;
   assign rsp_hours             = hour_ff;
   assign rsp_delay_remaining   = delay_ff;
   assign rsp_second_countdown  = sec_down_ff;
   assign rsp_minute_countdown  = min_down_ff;
   assign rsp_heartbeat_led_one = led_ff[0];
   assign rsp_heartbeat_led_two = led_ff[1];
   assign rsp_sample_trigger    = trig_ff;
   assign rsp_tick_total        = tick_ff;

endmodule

// File: hw/rtl/ttk_checker.sv
module ttk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_milliseconds,
   input logic [5:0]  rsp_seconds,
   input logic [5:0]  rsp_minutes,
   input logic [4:0]  rsp_hours,
   input logic        rsp_heartbeat_led_one,
   input logic        rsp_heartbeat_led_two,
   input logic        rsp_sample_trigger,
   input logic [15:0] rsp_tick_total
);

   // Every transfer in yields a result in the following cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after an input transfer");

   // The input side stalls only while a result waits untaken.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the result side");

   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_milliseconds <= ttk_pkg::MS_MAX && rsp_seconds <= ttk_pkg::SEC_MAX &&
                     rsp_minutes <= ttk_pkg::MIN_MAX && rsp_hours <= ttk_pkg::HOUR_MAX))
      else $error("clock field out of range");

   // A trigger comes from a tick that left a multiple of the period, so the
   // shown millisecond is one past such a multiple; the LEDs never both light.
   a_trigger_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_trigger) |->
         ((rsp_milliseconds & ttk_pkg::SAMPLE_MASK) == 10'd1 &&
          !(rsp_heartbeat_led_one && rsp_heartbeat_led_two)))
      else $error("sample trigger out of phase or both LEDs on");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_tick_total) &&
                                     $stable(rsp_milliseconds)))
      else $error("stalled result changed");

endmodule

bind tick_timekeeper_with_countdowns ttk_checker u_ttk_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_milliseconds      (rsp_milliseconds),
   .rsp_seconds           (rsp_seconds),
   .rsp_minutes           (rsp_minutes),
   .rsp_hours             (rsp_hours),
   .rsp_heartbeat_led_one (rsp_heartbeat_led_one),
   .rsp_heartbeat_led_two (rsp_heartbeat_led_two),
   .rsp_sample_trigger    (rsp_sample_trigger),
   .rsp_tick_total        (rsp_tick_total)
);
